### rtl/core/spnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spnp_pkg
// Shared item kinds, widths and helper functions for the nine-bit word packer.
// ----------------------------------------------------------------------------
package spnp_pkg;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SER_W   = 9;
	localparam int unsigned FIFO_W  = 16;
	localparam int unsigned PEND_W  = 4;
	localparam int unsigned ACC_W   = 15;
	localparam int unsigned CNT_W   = 4;

	localparam logic [KIND_W-1:0] KIND_CMD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [FIFO_W-1:0] fifo_word;
		logic              word_valid;
		logic              last;
	} out_item_t;

	function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = b[BYTE_W-1-i];
		end
		return r;
	endfunction

	// Number of FIFO words that zero padding produces before the pending count
	// returns to zero, given the bits pending at the start of a finish.
	function automatic logic [CNT_W-1:0] pad_words(input logic [PEND_W-1:0] p);
		logic [CNT_W-1:0] n;
		case (p)
			4'd0:    n = 4'd0;
			4'd1:    n = 4'd4;
			4'd2:    n = 4'd8;
			4'd3:    n = 4'd3;
			4'd4:    n = 4'd7;
			4'd5:    n = 4'd2;
			4'd6:    n = 4'd6;
			4'd7:    n = 4'd1;
			4'd8:    n = 4'd5;
			4'd9:    n = 4'd9;
			4'd10:   n = 4'd4;
			4'd11:   n = 4'd8;
			4'd12:   n = 4'd3;
			4'd13:   n = 4'd7;
			4'd14:   n = 4'd2;
			4'd15:   n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

### rtl/core/spnp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spnp_in_if
// Input channel of the packer: one byte or finish item per handshake.
// ----------------------------------------------------------------------------
interface spnp_in_if
	import spnp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink   (input valid, input kind, input byte_value, output ready);
endinterface
`default_nettype wire

### rtl/core/spnp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spnp_out_if
// Output channel of the packer: one 16-bit FIFO word per handshake.
// ----------------------------------------------------------------------------
interface spnp_out_if
	import spnp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [FIFO_W-1:0] fifo_word;
	logic              word_valid;
	logic              last;

	modport source (output valid, output fifo_word, output word_valid, output last,
		input ready);
	modport sink   (input valid, input fifo_word, input word_valid, input last,
		output ready);
endinterface
`default_nettype wire

### rtl/core/spi_nine_bit_word_packer.sv
`default_nettype none
// An accepted item passes through the input stage and then the result register.
// Throughput: one byte item per cycle while the output is not stalled; a finish item holds
// the input stage until its last padded FIFO word is emitted; the bits pending set how many.
// The input stage and the result register decouple the two channels, so an item is taken
// while a result still waits. Reset clears the pending bits, the count and all valid flags.
// ----------------------------------------------------------------------------
// spi_nine_bit_word_packer
// Packs command and data bytes into 9-bit serial words and emits 16-bit FIFO words,
// padding with zero words on finish until the message is aligned.
// ----------------------------------------------------------------------------
module spi_nine_bit_word_packer
	import spnp_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	spnp_in_if.sink    byte_in,
	spnp_out_if.source word_out
);

	logic              item_valid_s1;
	in_item_t          item_s1;
	logic [ACC_W-1:0]  acc_q;
	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  fin_left_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              out_free;
	logic              s1_fire;
	logic              s1_retire;
	logic              in_take;
	logic              is_byte;
	logic              is_fin;
	logic [SER_W-1:0]  ser_word;
	logic [23:0]       merged;
	logic [PEND_W:0]   pend_sum;
	logic [CNT_W-1:0]  n_pad;
	logic              emit;
	out_item_t         res;
	logic [ACC_W-1:0]  acc_d;
	logic [PEND_W-1:0] pend_d;
	logic [CNT_W-1:0]  fin_left_d;

	assign out_free = !out_valid_q || word_out.ready;
	assign s1_fire  = item_valid_s1 && out_free;
	assign is_byte  = (item_s1.kind == KIND_CMD) || (item_s1.kind == KIND_DATA);
	assign is_fin   = (item_s1.kind == KIND_FINISH);
	assign ser_word = {reverse_byte(item_s1.byte_value), item_s1.kind[0]};
	assign merged   = {9'd0, acc_q} | ({15'd0, ser_word} << pend_q);
	assign pend_sum = {1'b0, pend_q} + 5'(SER_W);
	assign n_pad    = pad_words(pend_q);

	always_comb begin
		emit       = 1'b0;
		res        = '0;
		acc_d      = acc_q;
		pend_d     = pend_q;
		fin_left_d = fin_left_q;
		s1_retire  = 1'b0;
		if (s1_fire) begin
			if (is_byte) begin
				s1_retire = 1'b1;
				pend_d    = pend_sum[PEND_W-1:0];
				if (pend_sum[PEND_W]) begin
					emit           = 1'b1;
					res.fifo_word  = merged[15:0];
					res.word_valid = 1'b1;
					acc_d          = {7'd0, merged[23:16]};
				end else begin
					acc_d = merged[ACC_W-1:0];
				end
			end else if (is_fin) begin
				emit = 1'b1;
				if (fin_left_q == '0) begin
					// First cycle of a finish: the pending bits go out in the first word.
					acc_d          = '0;
					pend_d         = '0;
					res.fifo_word  = {1'b0, acc_q};
					res.word_valid = (pend_q != '0);
					res.last       = (n_pad <= 4'd1);
					if (n_pad > 4'd1) begin
						fin_left_d = n_pad - 4'd1;
					end else begin
						s1_retire = 1'b1;
					end
				end else begin
					res.word_valid = 1'b1;
					res.last       = (fin_left_q == 4'd1);
					fin_left_d     = fin_left_q - 4'd1;
					s1_retire      = (fin_left_q == 4'd1);
				end
			end else begin
				s1_retire = 1'b1;
			end
		end
	end

	assign byte_in.ready = !item_valid_s1 || s1_retire;
	assign in_take       = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			acc_q         <= '0;
			pend_q        <= '0;
			fin_left_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_take) begin
				item_valid_s1 <= 1'b1;
			end else if (s1_retire) begin
				item_valid_s1 <= 1'b0;
			end
			acc_q      <= acc_d;
			pend_q     <= pend_d;
			fin_left_q <= fin_left_d;
			if (s1_fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (word_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.kind       <= byte_in.kind;
			item_s1.byte_value <= byte_in.byte_value;
		end
		if (s1_fire && emit) begin
			out_q <= res;
		end
	end

	assign word_out.valid      = out_valid_q;
	assign word_out.fifo_word  = out_q.fifo_word;
	assign word_out.word_valid = out_q.word_valid;
	assign word_out.last       = out_q.last;

`ifndef ASSERT_OFF
	// While padding words remain, the held item must be a finish and the state already cleared.
	a_fin_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_left_q != '0) |-> (item_valid_s1 && is_fin && acc_q == '0 && pend_q == '0))
		else $error("padding count set without a finish item in the input stage");

	// No new item may enter while a finish has more than its last padding word still to produce.
	a_no_take_while_padding: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_left_q > 4'd1) |-> !byte_in.ready)
		else $error("input accepted while padding words remain");

	// An empty result only ever closes a finish and carries a zero word.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.word_valid) |-> (out_q.last && out_q.fifo_word == '0))
		else $error("empty result not marked last or not zero");

	// With at most eight bits pending, accumulator bits 14 to 8 are zero.
	a_acc_above_pending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= 4'd8) |-> (acc_q[14:8] == '0))
		else $error("accumulator holds bits above the pending count");
`endif

endmodule
`default_nettype wire
